/* rtl/core/assert_macros.svh */
// assertion macros for the rtl files; complex_arith_unit includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CAU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");
`define CAU_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("%m: bad state");
`else
`define CAU_ASSERT(lbl, clk, rst, prop)
`define CAU_NEVER(lbl, clk, rst, expr)
`endif
`endif

/* rtl/core/cau_pkg.sv */
// types and constants of the complex arithmetic unit
package cau_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 8;

   localparam logic [1:0] ACT_ADD = 2'd0;
   localparam logic [1:0] ACT_SUB = 2'd1;
   localparam logic [1:0] ACT_MUL = 2'd2;
   localparam logic [1:0] ACT_DIV = 2'd3;

   typedef struct packed {
      logic [1:0]                   action;
      logic signed [DATA_WIDTH-1:0] a_real;
      logic signed [DATA_WIDTH-1:0] a_imag;
      logic signed [DATA_WIDTH-1:0] b_real;
      logic signed [DATA_WIDTH-1:0] b_imag;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] res_real;
      logic signed [DATA_WIDTH-1:0] res_imag;
      logic                         overflow;
      logic                         div_by_zero;
   } rsp_type;

   typedef struct packed {
      logic div;
      logic dbz;
   } ctl_type;

endpackage

/* rtl/core/cau_div_cell.sv */
// one restoring division step for both lanes, registered
module cau_div_cell #(
   parameter int W  = cau_pkg::DATA_WIDTH,
   parameter int XW = 3 * cau_pkg::DATA_WIDTH + 1 + cau_pkg::FRAC_BITS,
   parameter int K  = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  up_valid,
   input  cau_pkg::ctl_type      up_ctl,
   input  logic [2*W-1:0]        up_den,
   input  logic [1:0]            up_neg,
   input  logic [1:0]            up_big,
   input  logic [1:0][XW-1:0]    up_rem,
   input  logic [1:0][W-1:0]     up_quot,
   output logic                  dn_valid,
   output cau_pkg::ctl_type      dn_ctl,
   output logic [2*W-1:0]        dn_den,
   output logic [1:0]            dn_neg,
   output logic [1:0]            dn_big,
   output logic [1:0][XW-1:0]    dn_rem,
   output logic [1:0][W-1:0]     dn_quot
);

   localparam bit IS_TOP = (K == W);

   logic                  valid_ff;
   cau_pkg::ctl_type      ctl_ff;
   logic [2*W-1:0]        den_ff;
   logic [1:0]            neg_ff;
   logic [1:0]            big_ff, big_in;
   logic [1:0][XW-1:0]    rem_ff, rem_in;
   logic [1:0][W-1:0]     quot_ff, quot_in;
   logic [XW-1:0]         shifted;

   always_comb begin
      shifted = XW'(up_den) << K;
      big_in  = up_big;
      rem_in  = up_rem;
      quot_in = up_quot;
      for (int l = 0; l < 2; l++) begin
         if (up_ctl.div && up_rem[l] >= shifted) begin
            if (IS_TOP) begin
               big_in[l] = 1'b1;
            end else begin
               rem_in[l]  = up_rem[l] - shifted;
               quot_in[l] = up_quot[l] | (W'(1) << K);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff  <= up_ctl;
         den_ff  <= up_den;
         neg_ff  <= up_neg;
         big_ff  <= big_in;
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_ctl   = ctl_ff;
   assign dn_den   = den_ff;
   assign dn_neg   = neg_ff;
   assign dn_big   = big_ff;
   assign dn_rem   = rem_ff;
   assign dn_quot  = quot_ff;

endmodule

/* rtl/core/complex_arith_unit.sv */
// complex add, subtract, multiply and divide on signed fixed point words
// One word may enter every cycle unless req_stall is high. Each word passes one stage
// of multipliers, one stage that forms the sums and the divisor |b|^2, a row of DATA_WIDTH
// + 1 division cells (the first flags a too large quotient, each of the others settles
// one quotient bit of both components), and the saturating output register. Every word
// goes through the whole row, so results leave in order; empty stages close up while
// the output waits, so the input keeps taking words until the row is full. Saturated
// components raise overflow; a divide by zero returns zero and raises div_by_zero.
module complex_arith_unit #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cau_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cau_pkg::rsp_type rsp_word
);

`include "assert_macros.svh"

   localparam int W  = cau_pkg::DATA_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int NW = 2 * W + 1 + F;
   localparam int XW = (NW > 3 * W) ? NW : 3 * W;
   localparam int NC = W + 1;

   // stage 1: products and add/subtract sums
   logic                  v1_ff;
   logic [1:0]            act_ff;
   logic signed [2*W-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_br_ff, p_bi_ff;
   logic signed [2*W-1:0] p_rr_in, p_ii_in, p_ri_in, p_ir_in, p_br_in, p_bi_in;
   logic signed [W:0]     x_r_ff, x_i_ff, x_r_in, x_i_in;

   // stage 2: sums and divisor
   logic                  v2_ff;
   cau_pkg::ctl_type      ctl2_ff, ctl2_in;
   logic [2*W-1:0]        den2_ff, den2_in;
   logic [1:0]            neg2_ff, neg2_in;
   logic [1:0][XW-1:0]    rem2_ff, rem2_in;
   logic signed [2*W:0]   s_r, s_i;
   logic [2*W:0]          m_r, m_i;

   // division row
   logic [NC:0]           c_v;
   cau_pkg::ctl_type      c_ctl  [NC+1];
   logic [2*W-1:0]        c_den  [NC+1];
   logic [1:0]            c_neg  [NC+1];
   logic [1:0]            c_big  [NC+1];
   logic [1:0][XW-1:0]    c_rem  [NC+1];
   logic [1:0][W-1:0]     c_quot [NC+1];
   logic [NC-1:0]         cen;

   // output
   logic                  rsp_valid_ff;
   cau_pkg::rsp_type      rsp_ff, rsp_in;
   logic                  en_out, en1, en2;
   logic [XW-1:0]         mag_fin [2];
   logic [W-1:0]          val_fin [2];
   logic [1:0]            ovf_fin;

   localparam logic [XW-1:0] NEG_LIM = XW'(1) << (W - 1);

   always_comb begin
      en_out      = !rsp_valid_ff || !rsp_stall;
      cen[NC-1]   = !c_v[NC] || en_out;
      for (int j = NC - 2; j >= 0; j--) begin
         cen[j] = !c_v[j+1] || cen[j+1];
      end
      en2 = !v2_ff || cen[0];
      en1 = !v1_ff || en2;
   end

   assign req_stall = !en1;

   always_comb begin
      p_rr_in = (2*W)'(req_word.a_real) * (2*W)'(req_word.b_real);
      p_ii_in = (2*W)'(req_word.a_imag) * (2*W)'(req_word.b_imag);
      p_ri_in = (2*W)'(req_word.a_real) * (2*W)'(req_word.b_imag);
      p_ir_in = (2*W)'(req_word.a_imag) * (2*W)'(req_word.b_real);
      p_br_in = (2*W)'(req_word.b_real) * (2*W)'(req_word.b_real);
      p_bi_in = (2*W)'(req_word.b_imag) * (2*W)'(req_word.b_imag);
      if (req_word.action == cau_pkg::ACT_SUB) begin
         x_r_in = (W+1)'(req_word.a_real) - (W+1)'(req_word.b_real);
         x_i_in = (W+1)'(req_word.a_imag) - (W+1)'(req_word.b_imag);
      end else begin
         x_r_in = (W+1)'(req_word.a_real) + (W+1)'(req_word.b_real);
         x_i_in = (W+1)'(req_word.a_imag) + (W+1)'(req_word.b_imag);
      end
   end

   always_comb begin
      den2_in = p_br_ff[2*W-1:0] + p_bi_ff[2*W-1:0];
      ctl2_in = '0;
      case (act_ff)
         cau_pkg::ACT_ADD, cau_pkg::ACT_SUB: begin
            s_r = (2*W+1)'(x_r_ff);
            s_i = (2*W+1)'(x_i_ff);
         end
         cau_pkg::ACT_MUL: begin
            s_r = (2*W+1)'(p_rr_ff) - (2*W+1)'(p_ii_ff);
            s_i = (2*W+1)'(p_ri_ff) + (2*W+1)'(p_ir_ff);
         end
         default: begin
            s_r = (2*W+1)'(p_rr_ff) + (2*W+1)'(p_ii_ff);
            s_i = (2*W+1)'(p_ir_ff) - (2*W+1)'(p_ri_ff);
         end
      endcase
      m_r = s_r[2*W] ? (2*W+1)'(-s_r) : s_r;
      m_i = s_i[2*W] ? (2*W+1)'(-s_i) : s_i;
      neg2_in = {s_i[2*W], s_r[2*W]};
      case (act_ff)
         cau_pkg::ACT_MUL: begin
            rem2_in[0] = XW'(m_r >> F);
            rem2_in[1] = XW'(m_i >> F);
         end
         cau_pkg::ACT_DIV: begin
            rem2_in[0] = XW'(m_r) << F;
            rem2_in[1] = XW'(m_i) << F;
            ctl2_in.div = (den2_in != '0);
            ctl2_in.dbz = (den2_in == '0);
         end
         default: begin
            rem2_in[0] = XW'(m_r);
            rem2_in[1] = XW'(m_i);
         end
      endcase
      if (ctl2_in.dbz) begin
         neg2_in = '0;
         rem2_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en_out) begin
            rsp_valid_ff <= c_v[NC];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         act_ff  <= req_word.action;
         p_rr_ff <= p_rr_in;
         p_ii_ff <= p_ii_in;
         p_ri_ff <= p_ri_in;
         p_ir_ff <= p_ir_in;
         p_br_ff <= p_br_in;
         p_bi_ff <= p_bi_in;
         x_r_ff  <= x_r_in;
         x_i_ff  <= x_i_in;
      end
      if (en2) begin
         ctl2_ff <= ctl2_in;
         den2_ff <= den2_in;
         neg2_ff <= neg2_in;
         rem2_ff <= rem2_in;
      end
      if (en_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign c_v[0]    = v2_ff;
   assign c_ctl[0]  = ctl2_ff;
   assign c_den[0]  = den2_ff;
   assign c_neg[0]  = neg2_ff;
   assign c_big[0]  = '0;
   assign c_rem[0]  = rem2_ff;
   assign c_quot[0] = '0;

   for (genvar j = 0; j < NC; j++) begin : g_cell
      cau_div_cell #(
         .W  (W),
         .XW (XW),
         .K  (W - j)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (cen[j]),
         .up_valid (c_v[j]),
         .up_ctl   (c_ctl[j]),
         .up_den   (c_den[j]),
         .up_neg   (c_neg[j]),
         .up_big   (c_big[j]),
         .up_rem   (c_rem[j]),
         .up_quot  (c_quot[j]),
         .dn_valid (c_v[j+1]),
         .dn_ctl   (c_ctl[j+1]),
         .dn_den   (c_den[j+1]),
         .dn_neg   (c_neg[j+1]),
         .dn_big   (c_big[j+1]),
         .dn_rem   (c_rem[j+1]),
         .dn_quot  (c_quot[j+1])
      );
   end

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (c_ctl[NC].div) begin
            mag_fin[l] = c_big[NC][l] ? (XW'(1) << W) : XW'(c_quot[NC][l]);
         end else begin
            mag_fin[l] = c_rem[NC][l];
         end
         ovf_fin[l] = 1'b0;
         if (c_neg[NC][l]) begin
            if (mag_fin[l] > NEG_LIM) begin
               val_fin[l] = NEG_LIM[W-1:0];
               ovf_fin[l] = 1'b1;
            end else begin
               val_fin[l] = W'(~mag_fin[l] + XW'(1));
            end
         end else begin
            if (mag_fin[l] > NEG_LIM - XW'(1)) begin
               val_fin[l] = W'(NEG_LIM - XW'(1));
               ovf_fin[l] = 1'b1;
            end else begin
               val_fin[l] = mag_fin[l][W-1:0];
            end
         end
      end
      rsp_in.res_real    = val_fin[0];
      rsp_in.res_imag    = val_fin[1];
      rsp_in.overflow    = |ovf_fin;
      rsp_in.div_by_zero = c_ctl[NC].dbz;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `CAU_ASSERT(a_dbz_zero, clock, reset, rsp_valid_ff && rsp_ff.div_by_zero |-> rsp_ff.res_real == '0 && rsp_ff.res_imag == '0 && !rsp_ff.overflow)
   `CAU_NEVER(a_ctl_excl, clock, reset, v2_ff && ctl2_ff.div && ctl2_ff.dbz)
   `CAU_ASSERT(a_rem_below, clock, reset, c_v[NC] && c_ctl[NC].div && c_big[NC] == 2'b00 |-> c_rem[NC][0] < XW'(c_den[NC]) && c_rem[NC][1] < XW'(c_den[NC]))

endmodule

/* bench/tb_complex_arith_unit.sv */
// testbench of the complex arithmetic unit: random and corner words checked against a predictor
module tb_complex_arith_unit;

   localparam int LATENCY = cau_pkg::DATA_WIDTH + 4;
   localparam logic signed [15:0] MAXV = 16'sh7fff;
   localparam logic signed [15:0] MINV = -16'sh8000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   cau_pkg::req_type req_word = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   cau_pkg::rsp_type rsp_word;

   cau_pkg::req_type pending_words[$];
   cau_pkg::rsp_type expected_results[$];
   int      mismatches = 0;
   bit      hold_sender = 1'b0;
   bit      words_done = 1'b0;
   int      send_gap = 0;
   int      stall_left = 0;

   complex_arith_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // saturate a wide value to the output word
   function automatic logic signed [15:0] clamp(input longint v, inout logic ovf);
      if (v > 32767) begin
         ovf = 1'b1;
         return MAXV;
      end
      if (v < -32768) begin
         ovf = 1'b1;
         return MINV;
      end
      return v[15:0];
   endfunction

   // quotient num * 2^FRAC_BITS / den truncated toward zero, kept wide enough to saturate
   function automatic longint scaled_div(input longint num, input longint den);
      longint mag;
      longint q;
      mag = num < 0 ? -num : num;
      q = (mag <<< cau_pkg::FRAC_BITS) / den;
      if (q > 40000) q = 40000;
      return num < 0 ? -q : q;
   endfunction

   function automatic cau_pkg::rsp_type compute_result(input cau_pkg::req_type w);
      cau_pkg::rsp_type r;
      longint  ar, ai, br, bi, xr, xi, den;
      logic    ovf;
      ar = w.a_real; ai = w.a_imag; br = w.b_real; bi = w.b_imag;
      ovf = 1'b0;
      r = '0;
      case (w.action)
         cau_pkg::ACT_ADD: begin xr = ar + br; xi = ai + bi; end
         cau_pkg::ACT_SUB: begin xr = ar - br; xi = ai - bi; end
         cau_pkg::ACT_MUL: begin
            xr = ar * br - ai * bi;
            xi = ar * bi + br * ai;
            xr = xr < 0 ? -((-xr) >>> cau_pkg::FRAC_BITS) : xr >>> cau_pkg::FRAC_BITS;
            xi = xi < 0 ? -((-xi) >>> cau_pkg::FRAC_BITS) : xi >>> cau_pkg::FRAC_BITS;
         end
         default: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               r.div_by_zero = 1'b1;
               return r;
            end
            xr = scaled_div(ar * br + ai * bi, den);
            xi = scaled_div(br * ai - ar * bi, den);
         end
      endcase
      r.res_real = clamp(xr, ovf);
      r.res_imag = clamp(xi, ovf);
      r.overflow = ovf;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatches++;
   endtask

   function automatic logic signed [15:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return MAXV;
         1: return MINV;
         2: return 16'(signed'($urandom_range(0, 8)) - 4);
         3: return 16'(signed'($urandom_range(0, 2048)) - 1024);
         default: return 16'($urandom);
      endcase
   endfunction

   // driver
   always @(posedge clock) begin : drive_blk
      int gap_draw;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(compute_result(req_word));
            gap_draw = $urandom_range(0, 3) == 0 ? $urandom_range(0, 19) : 0;
            if (gap_draw == 0 && !hold_sender && pending_words.size() > 0) begin
               req_word <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
               send_gap <= gap_draw > 0 ? gap_draw - 1 : 0;
            end
         end else if (!req_valid) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
            end else if (!hold_sender && pending_words.size() > 0) begin
               req_word <= pending_words.pop_front();
               req_valid <= 1'b1;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : monitor_blk
      int stall_draw;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected word", 0, 0);
            end else begin
               cau_pkg::rsp_type e;
               e = expected_results.pop_front();
               if (rsp_word.res_real !== e.res_real)
                  report_mismatch("res_real", rsp_word.res_real, e.res_real);
               if (rsp_word.res_imag !== e.res_imag)
                  report_mismatch("res_imag", rsp_word.res_imag, e.res_imag);
               if (rsp_word.overflow !== e.overflow)
                  report_mismatch("overflow", rsp_word.overflow, e.overflow);
               if (rsp_word.div_by_zero !== e.div_by_zero)
                  report_mismatch("div_by_zero", rsp_word.div_by_zero, e.div_by_zero);
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (rsp_valid && !rsp_stall) begin
            stall_draw = $urandom_range(0, 3) == 0 ? $urandom_range(0, 19) : 0;
            if (stall_draw > 0) begin
               stall_left <= stall_draw - 1;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      cau_pkg::req_type w;
      // corner words
      for (int op = 0; op < 4; op++) begin
         w.action = op[1:0];
         w.a_real = MAXV; w.a_imag = MINV; w.b_real = MAXV; w.b_imag = MINV;
         pending_words.push_back(w);
         w.a_real = MINV; w.a_imag = MINV; w.b_real = MINV; w.b_imag = MINV;
         pending_words.push_back(w);
         w.a_real = 16'sd256; w.a_imag = -16'sd512; w.b_real = 16'sd0; w.b_imag = 16'sd0;
         pending_words.push_back(w);
         w.a_real = MAXV; w.a_imag = MAXV; w.b_real = 16'sd1; w.b_imag = 16'sd0;
         pending_words.push_back(w);
         w.a_real = -16'sd3; w.a_imag = 16'sd5; w.b_real = -16'sd1; w.b_imag = 16'sd1;
         pending_words.push_back(w);
      end
      for (int n = 0; n < 1950; n++) begin
         w.action = 2'($urandom);
         w.a_real = pick_operand(); w.a_imag = pick_operand();
         w.b_real = pick_operand(); w.b_imag = pick_operand();
         if ($urandom_range(0, 30) == 0) begin
            w.b_real = 0;
            w.b_imag = 0;
         end
         pending_words.push_back(w);
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // let the pipeline drain completely once mid-run
      while (pending_words.size() >= 1000) @(posedge clock);
      hold_sender = 1'b1;
      while (req_valid || expected_results.size() != 0) @(posedge clock);
      hold_sender = 1'b0;
      while (pending_words.size() != 0 || req_valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      words_done = 1'b1;
      if (mismatches == 0 && expected_results.size() == 0)
         $display("tb_complex_arith_unit: PASS");
      else
         $display("tb_complex_arith_unit: FAIL");
      $finish;
   end

   initial begin
      #2000000;
      if (!words_done) begin
         $display("tb_complex_arith_unit: FAIL");
         $finish;
      end
   end

endmodule
